// File: src/per_source_resequencing_buffer_defines.svh
// ---------------------------------------------------------------------------
// per_source_resequencing_buffer_defines
// Assertion macros used by the resequencing buffer datapath.
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_RESEQUENCING_BUFFER_DEFINES_SVH
`define PER_SOURCE_RESEQUENCING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSRB_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSRB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/psrb_pkg.sv
// ---------------------------------------------------------------------------
// psrb_pkg
// Types, codes and helpers of the per-source resequencing buffer.
// ---------------------------------------------------------------------------
package psrb_pkg;

  localparam int NUM_SOURCES_DEF      = 8;
  localparam int SLOTS_PER_SOURCE_DEF = 16;
  localparam int HANDLE_BITS_DEF      = 16;
  localparam int TIME_BITS_DEF        = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_TAKE   = 3'd1,
    OP_NEXT   = 3'd2,
    OP_EXPIRY = 3'd3,
    OP_PURGE  = 3'd4
  } op_t;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_NONE   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_PURGED = 3'd4;

  typedef enum logic [3:0] {
    RES_NONE,
    RES_ADD,
    RES_DUP,
    RES_FULL,
    RES_TAKE,
    RES_REL,
    RES_EXP,
    RES_PEMPTY,
    RES_PITEM
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SRC,
    S_SRD,
    S_SEV,
    S_SDONE,
    S_UPRD,
    S_UPWR,
    S_DNRD,
    S_DNWR,
    S_PRD,
    S_PEV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic dispatch;
    logic src_skip;
    logic src_begin;
    logic scan_rd;
    logic scan_ev;
    logic next_eval;
    logic exp_acc;
    logic ins_begin;
    logic shup_rd;
    logic shup_wr;
    logic ins_write;
    logic shdn_begin;
    logic shdn_rd;
    logic shdn_wr;
    logic shdn_end;
    logic purge_rd;
    logic purge_ev;
    logic stage;
    res_t res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic hit_empty;
    logic tbl_full;
    logic idx_end;
    logic found;
    logic slots_full;
    logic p_end;
    logic p_empty;
    logic rel;
    logic up_done;
    logic dn_done;
    logic out_free;
    logic res_last;
  } stat_t;

  // a follows b in serial order: (a - b) mod 256 lies in 1..127
  function automatic logic serial_gt(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = a - b;
    return (d != 8'd0) && !d[7];
  endfunction

endpackage

// File: src/psrb_ram.sv
// ---------------------------------------------------------------------------
// psrb_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module psrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/psrb_ctrl.sv
// ---------------------------------------------------------------------------
// psrb_ctrl
// Sequencer: steps the datapath through lookup, slot scans and shifts.
// ---------------------------------------------------------------------------
module psrb_ctrl import psrb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        case (st.op)
          OP_ADD: begin
            if (st.hit || !st.tbl_full) begin
              state_next = S_SRD;
            end else begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_FULL;
              state_next = S_EMIT;
            end
          end
          OP_TAKE: begin
            if (st.hit) begin
              state_next = S_SRD;
            end else begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_NONE;
              state_next = S_EMIT;
            end
          end
          OP_NEXT, OP_EXPIRY: begin
            state_next = S_SRC;
          end
          OP_PURGE: begin
            if (!st.hit) begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_NONE;
              state_next = S_EMIT;
            end else if (st.hit_empty) begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_PEMPTY;
              state_next = S_EMIT;
            end else begin
              state_next = S_PRD;
            end
          end
          default: begin
            cmd.stage  = 1'b1;
            cmd.res    = RES_NONE;
            state_next = S_EMIT;
          end
        endcase
      end
      S_SRC: begin
        if (st.p_end) begin
          cmd.stage  = 1'b1;
          cmd.res    = (st.op == OP_NEXT) ? RES_NONE : RES_EXP;
          state_next = S_EMIT;
        end else if (st.p_empty) begin
          cmd.src_skip = 1'b1;
        end else begin
          cmd.src_begin = 1'b1;
          state_next    = S_SRD;
        end
      end
      S_SRD: begin
        if (st.idx_end) begin
          state_next = S_SDONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SEV;
        end
      end
      S_SEV: begin
        cmd.scan_ev = 1'b1;
        state_next  = S_SRD;
      end
      S_SDONE: begin
        case (st.op)
          OP_ADD: begin
            if (st.found) begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_DUP;
              state_next = S_EMIT;
            end else if (st.slots_full) begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_FULL;
              state_next = S_EMIT;
            end else begin
              cmd.ins_begin = 1'b1;
              state_next    = S_UPRD;
            end
          end
          OP_TAKE: begin
            if (!st.found) begin
              cmd.stage  = 1'b1;
              cmd.res    = RES_NONE;
              state_next = S_EMIT;
            end else begin
              cmd.shdn_begin = 1'b1;
              state_next     = S_DNRD;
            end
          end
          OP_NEXT: begin
            cmd.next_eval = 1'b1;
            if (st.rel) begin
              cmd.shdn_begin = 1'b1;
              state_next     = S_DNRD;
            end else begin
              cmd.src_skip = 1'b1;
              state_next   = S_SRC;
            end
          end
          default: begin
            cmd.exp_acc  = 1'b1;
            cmd.src_skip = 1'b1;
            state_next   = S_SRC;
          end
        endcase
      end
      S_UPRD: begin
        if (st.up_done) begin
          cmd.ins_write = 1'b1;
          cmd.stage     = 1'b1;
          cmd.res       = RES_ADD;
          state_next    = S_EMIT;
        end else begin
          cmd.shup_rd = 1'b1;
          state_next  = S_UPWR;
        end
      end
      S_UPWR: begin
        cmd.shup_wr = 1'b1;
        state_next  = S_UPRD;
      end
      S_DNRD: begin
        if (st.dn_done) begin
          cmd.shdn_end = 1'b1;
          cmd.stage    = 1'b1;
          cmd.res      = (st.op == OP_TAKE) ? RES_TAKE : RES_REL;
          state_next   = S_EMIT;
        end else begin
          cmd.shdn_rd = 1'b1;
          state_next  = S_DNWR;
        end
      end
      S_DNWR: begin
        cmd.shdn_wr = 1'b1;
        state_next  = S_DNRD;
      end
      S_PRD: begin
        cmd.purge_rd = 1'b1;
        state_next   = S_PEV;
      end
      S_PEV: begin
        cmd.stage    = 1'b1;
        cmd.res      = RES_PITEM;
        cmd.purge_ev = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.op == OP_PURGE && !st.res_last) begin
            state_next = S_PRD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/psrb_dp.sv
// ---------------------------------------------------------------------------
// psrb_dp
// Datapath: source table, slot RAM, scan registers and result register.
// ---------------------------------------------------------------------------
`include "per_source_resequencing_buffer_defines.svh"

module psrb_dp import psrb_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int SLOTS_PER_SOURCE = SLOTS_PER_SOURCE_DEF,
  parameter int HANDLE_BITS      = HANDLE_BITS_DEF,
  parameter int TIME_BITS        = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_source,
  input  logic [7:0]  in_seq,
  input  logic [31:0] in_expire,
  input  logic [31:0] in_now,
  input  logic [15:0] in_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_handle,
  output logic [7:0]  out_seq,
  output logic [31:0] out_source,
  output logic [31:0] out_min,
  output logic        out_hole,
  output logic        out_last
);

  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CNT_W = $clog2(NUM_SOURCES + 1);
  localparam int CW    = $clog2(SLOTS_PER_SOURCE + 1);
  localparam int DEPTH = NUM_SOURCES * SLOTS_PER_SOURCE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 8 + TIME_BITS + HANDLE_BITS;

  // captured request
  op_t                  op_r;
  logic [31:0]          addr_r;
  logic [7:0]           seq_r;
  logic [TIME_BITS-1:0] exp_r, now_r;
  logic [HANDLE_BITS-1:0] hdl_r;

  // source table, position 0 is the newest source
  logic [31:0]      src_addr  [NUM_SOURCES];
  logic             chain_act [NUM_SOURCES];
  logic [7:0]       chain_sq  [NUM_SOURCES];
  logic [CW-1:0]    cnt       [NUM_SOURCES];
  logic [SRC_W-1:0] phys      [NUM_SOURCES];
  logic [CNT_W-1:0] count;

  // walk and scan registers
  logic [CNT_W-1:0]       pos;
  logic [SRC_W-1:0]       cur_phys;
  logic [CW-1:0]          cur_cnt, idx, jx, ins_i, ins_idx, fidx;
  logic                   found, ins_found;
  logic [TIME_BITS-1:0]   min_r, gmin, f_exp;
  logic [7:0]             f_seq;
  logic [HANDLE_BITS-1:0] f_hdl, t_hdl;

  // staged result
  logic [2:0]  stg_status;
  logic [15:0] stg_handle;
  logic [7:0]  stg_seq;
  logic [31:0] stg_source, stg_min;
  logic        stg_hole, stg_last;

  // slot RAM
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [EW-1:0]          ram_wdata, rd_data;
  logic [HANDLE_BITS-1:0] r_hdl;
  logic [TIME_BITS-1:0]   r_exp;
  logic [7:0]             r_seq;

  logic             hit;
  logic [SRC_W-1:0] hit_idx;
  logic [SRC_W-1:0] pos_i, count_i;
  logic             chain_c, skip1, mism, expired;
  logic [7:0]       cseq1;

  function automatic logic [AW-1:0] slot_addr(logic [SRC_W-1:0] ph, logic [CW-1:0] sl);
    return AW'(AW'(ph) * AW'(SLOTS_PER_SOURCE) + AW'(sl));
  endfunction

  assign pos_i   = pos[SRC_W-1:0];
  assign count_i = count[SRC_W-1:0];
  assign r_hdl   = rd_data[HANDLE_BITS-1:0];
  assign r_exp   = rd_data[HANDLE_BITS+TIME_BITS-1:HANDLE_BITS];
  assign r_seq   = rd_data[EW-1:HANDLE_BITS+TIME_BITS];

  // newest matching source wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int p = NUM_SOURCES - 1; p >= 0; p--) begin
      if (CNT_W'(p) < count && src_addr[p] == addr_r) begin
        hit     = 1'b1;
        hit_idx = SRC_W'(p);
      end
    end
  end

  // release rule for the source under the walk
  assign chain_c = chain_act[pos_i];
  assign cseq1   = chain_sq[pos_i] + 8'd1;
  assign skip1   = (min_r > now_r) && !chain_c;
  assign mism    = chain_c && (f_seq != cseq1);
  assign expired = (f_exp <= now_r);

  always_comb begin
    st            = '0;
    st.op         = op_r;
    st.hit        = hit;
    st.hit_empty  = (cnt[hit_idx] == '0);
    st.tbl_full   = (count == CNT_W'(NUM_SOURCES));
    st.idx_end    = (idx == cur_cnt);
    st.found      = found;
    st.slots_full = (cur_cnt == CW'(SLOTS_PER_SOURCE));
    st.p_end      = (pos == count);
    st.p_empty    = (cnt[pos_i] == '0);
    st.rel        = !skip1 && (expired || !mism);
    st.up_done    = (jx == ins_i);
    st.dn_done    = (CW'(jx + 1'b1) >= cur_cnt);
    st.out_free   = !out_valid || out_ready;
    st.res_last   = stg_last;
  end

  always_comb begin
    ram_re = cmd.scan_rd | cmd.purge_rd | cmd.shup_rd | cmd.shdn_rd;
    if (cmd.shup_rd) begin
      ram_raddr = slot_addr(cur_phys, CW'(jx - 1'b1));
    end else if (cmd.shdn_rd) begin
      ram_raddr = slot_addr(cur_phys, CW'(jx + 1'b1));
    end else begin
      ram_raddr = slot_addr(cur_phys, idx);
    end
    ram_we = cmd.shup_wr | cmd.shdn_wr | cmd.ins_write;
    if (cmd.ins_write) begin
      ram_waddr = slot_addr(cur_phys, ins_i);
      ram_wdata = {seq_r, exp_r, hdl_r};
    end else begin
      ram_waddr = slot_addr(cur_phys, jx);
      ram_wdata = rd_data;
    end
  end

  psrb_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int j = 0; j < NUM_SOURCES; j++) begin
        chain_act[j] <= 1'b0;
        phys[j]      <= SRC_W'(j);
      end
    end else begin
      if (cmd.load_in) begin
        op_r   <= op_t'(in_op);
        addr_r <= in_source;
        seq_r  <= in_seq;
        exp_r  <= TIME_BITS'(in_expire);
        now_r  <= TIME_BITS'(in_now);
        hdl_r  <= HANDLE_BITS'(in_handle);
      end
      if (cmd.dispatch) begin
        idx       <= '0;
        found     <= 1'b0;
        ins_found <= 1'b0;
        gmin      <= '0;
        pos       <= '0;
        case (op_r)
          OP_ADD, OP_TAKE: begin
            if (hit) begin
              pos      <= CNT_W'(hit_idx);
              cur_phys <= phys[hit_idx];
              cur_cnt  <= cnt[hit_idx];
            end else if (op_r == OP_ADD && count != CNT_W'(NUM_SOURCES)) begin
              // open a new source at the head, reuse the first free block
              for (int j = NUM_SOURCES - 1; j >= 1; j--) begin
                if (CNT_W'(j) <= count) begin
                  phys[j]      <= phys[j-1];
                  src_addr[j]  <= src_addr[j-1];
                  chain_act[j] <= chain_act[j-1];
                  chain_sq[j]  <= chain_sq[j-1];
                  cnt[j]       <= cnt[j-1];
                end
              end
              phys[0]      <= phys[count_i];
              src_addr[0]  <= addr_r;
              chain_act[0] <= 1'b0;
              cnt[0]       <= '0;
              cur_phys     <= phys[count_i];
              cur_cnt      <= '0;
              count        <= count + 1'b1;
            end
          end
          OP_PURGE: begin
            if (hit) begin
              cur_phys <= phys[hit_idx];
              cur_cnt  <= cnt[hit_idx];
              for (int j = 0; j < NUM_SOURCES - 1; j++) begin
                if (j >= int'(hit_idx) && CNT_W'(j + 1) < count) begin
                  phys[j]      <= phys[j+1];
                  src_addr[j]  <= src_addr[j+1];
                  chain_act[j] <= chain_act[j+1];
                  chain_sq[j]  <= chain_sq[j+1];
                  cnt[j]       <= cnt[j+1];
                end
              end
              for (int j = 0; j < NUM_SOURCES; j++) begin
                if (CNT_W'(j) == CNT_W'(count - 1'b1)) begin
                  phys[j] <= phys[hit_idx];
                end
              end
              count <= count - 1'b1;
            end
          end
          default: begin
            pos <= '0;
          end
        endcase
      end
      if (cmd.src_skip) begin
        if (op_r == OP_NEXT && cnt[pos_i] == '0) begin
          chain_act[pos_i] <= 1'b0;
        end
        pos <= pos + 1'b1;
      end
      if (cmd.src_begin) begin
        cur_phys  <= phys[pos_i];
        cur_cnt   <= cnt[pos_i];
        idx       <= '0;
        found     <= 1'b0;
        ins_found <= 1'b0;
      end
      if (cmd.scan_ev) begin
        if (idx == '0) begin
          min_r <= r_exp;
          f_seq <= r_seq;
          f_hdl <= r_hdl;
          f_exp <= r_exp;
        end else if (r_exp < min_r) begin
          min_r <= r_exp;
        end
        if (r_seq == seq_r && !found) begin
          found <= 1'b1;
          fidx  <= idx;
          t_hdl <= r_hdl;
        end
        if (!ins_found && serial_gt(r_seq, seq_r)) begin
          ins_found <= 1'b1;
          ins_idx   <= idx;
        end
        idx <= idx + 1'b1;
      end
      if (cmd.next_eval && !skip1) begin
        if (expired) begin
          chain_act[pos_i] <= 1'b1;
          chain_sq[pos_i]  <= f_seq;
        end else if (mism) begin
          chain_act[pos_i] <= 1'b0;
        end else if (chain_c) begin
          chain_sq[pos_i] <= f_seq;
        end
      end
      if (cmd.exp_acc && min_r != '0 && (gmin == '0 || min_r < gmin)) begin
        gmin <= min_r;
      end
      if (cmd.ins_begin) begin
        jx    <= cur_cnt;
        ins_i <= ins_found ? ins_idx : cur_cnt;
      end
      if (cmd.shup_wr) begin
        jx <= jx - 1'b1;
      end
      if (cmd.ins_write) begin
        cnt[pos_i] <= cnt[pos_i] + 1'b1;
      end
      if (cmd.shdn_begin) begin
        jx <= (op_r == OP_TAKE) ? fidx : '0;
      end
      if (cmd.shdn_wr) begin
        jx <= jx + 1'b1;
      end
      if (cmd.shdn_end) begin
        cnt[pos_i] <= cnt[pos_i] - 1'b1;
      end
      if (cmd.purge_ev) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // stage one result
  always_ff @(posedge clk) begin
    if (cmd.stage) begin
      stg_status <= ST_NONE;
      stg_handle <= '0;
      stg_seq    <= '0;
      stg_source <= '0;
      stg_min    <= '0;
      stg_hole   <= 1'b0;
      stg_last   <= 1'b1;
      case (cmd.res)
        RES_ADD: begin
          stg_status <= ST_DONE;
          stg_handle <= 16'(hdl_r);
          stg_seq    <= seq_r;
          stg_source <= addr_r;
          stg_hole   <= (cur_cnt == '0);
        end
        RES_DUP, RES_FULL: begin
          stg_status <= (cmd.res == RES_DUP) ? ST_DUP : ST_FULL;
          stg_handle <= 16'(hdl_r);
          stg_seq    <= seq_r;
          stg_source <= addr_r;
        end
        RES_TAKE: begin
          stg_status <= ST_DONE;
          stg_handle <= 16'(t_hdl);
          stg_seq    <= seq_r;
          stg_source <= addr_r;
        end
        RES_REL: begin
          stg_status <= ST_DONE;
          stg_handle <= 16'(f_hdl);
          stg_seq    <= f_seq;
          stg_source <= src_addr[pos_i];
        end
        RES_EXP: begin
          stg_status <= (gmin != '0) ? ST_DONE : ST_NONE;
          stg_min    <= 32'(gmin);
        end
        RES_PEMPTY: begin
          stg_status <= ST_DONE;
          stg_source <= addr_r;
        end
        RES_PITEM: begin
          stg_status <= ST_PURGED;
          stg_handle <= 16'(r_hdl);
          stg_seq    <= r_seq;
          stg_source <= addr_r;
          stg_last   <= (CW'(idx + 1'b1) == cur_cnt);
        end
        default: begin
          stg_status <= ST_NONE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= stg_status;
      out_handle <= stg_handle;
      out_seq    <= stg_seq;
      out_source <= stg_source;
      out_min    <= stg_min;
      out_hole   <= stg_hole;
      out_last   <= stg_last;
    end
  end

  `PSRB_CHECK(a_count_bound, 1'b1, count <= CNT_W'(NUM_SOURCES), "source count overflow")
  `PSRB_CHECK(a_emit_free, cmd.emit, !out_valid || out_ready, "result overwritten")
  `PSRB_CHECK(a_ins_room, cmd.ins_write, cur_cnt < CW'(SLOTS_PER_SOURCE), "slot overflow")
  `PSRB_CHECK_NEXT(a_emit_valid, cmd.emit, out_valid, "emitted result not valid")

endmodule

// File: src/per_source_resequencing_buffer.sv
// ---------------------------------------------------------------------------
// per_source_resequencing_buffer
// Per-source packet resequencing buffer with expiry-driven release.
// ---------------------------------------------------------------------------
// One request at a time: a request is taken only while the sequencer is
// idle, and it produces one result (a purge of a nonempty source produces one
// per held packet, the final one with tlast). Packet entries live in a slot
// RAM with one write and one registered read port; every slot visit is a
// read, then a use of the read data. Add and take scan the source's n held
// slots and then shift the tail from slot i. Next expiry visits every held
// slot of every source in table order; next release visits them in the same
// order but stops at the first source that releases a packet. Purge reads
// and reports one held packet at a time. A result waits in the output
// register while the next request is taken.
module per_source_resequencing_buffer import psrb_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int SLOTS_PER_SOURCE = SLOTS_PER_SOURCE_DEF,
  parameter int HANDLE_BITS      = HANDLE_BITS_DEF,
  parameter int TIME_BITS        = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // source_addr[31:0], seq[39:32], expire_time[71:40], now[103:72],
  // packet_handle[119:104]
  input  logic [119:0] s_axis_tdata,
  // op[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_handle[15:0], out_seq[23:16], out_source[55:24], min_expire[87:56]
  output logic [87:0]  m_axis_tdata,
  // status[2:0], hole_created[3]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  cmd_t  cmd;
  stat_t st;

  logic [2:0]  status;
  logic [15:0] out_handle;
  logic [7:0]  out_seq;
  logic [31:0] out_source, min_expire;
  logic        hole_created;

  // sequencer: owns the transfer acceptance on the request side
  psrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // source table, slot RAM and result register
  psrb_dp #(
    .NUM_SOURCES      (NUM_SOURCES),
    .SLOTS_PER_SOURCE (SLOTS_PER_SOURCE),
    .HANDLE_BITS      (HANDLE_BITS),
    .TIME_BITS        (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_op      (s_axis_tuser),
    .in_source  (s_axis_tdata[31:0]),
    .in_seq     (s_axis_tdata[39:32]),
    .in_expire  (s_axis_tdata[71:40]),
    .in_now     (s_axis_tdata[103:72]),
    .in_handle  (s_axis_tdata[119:104]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_handle (out_handle),
    .out_seq    (out_seq),
    .out_source (out_source),
    .out_min    (min_expire),
    .out_hole   (hole_created),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {min_expire, out_source, out_seq, out_handle};
  assign m_axis_tuser = {hole_created, status};

endmodule

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-source resequencing buffer: drives add,
// take, next-release, next-expiry, purge and reserved-op requests, predicts
// every result with a behavioral copy of the source table and slots, and
// checks each returned transfer field by field.
// ---------------------------------------------------------------------------
module tb_top;
  import psrb_pkg::*;

  localparam int NSRC = NUM_SOURCES_DEF;
  localparam int NSLT = SLOTS_PER_SOURCE_DEF;
  localparam int WDOG_LIMIT = 20000;
  localparam int QUIET_LO = 3000;
  localparam int QUIET_HI = 4500;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [7:0]  seq;
    logic [31:0] expire;
    logic [31:0] now;
    logic [15:0] handle;
    bit          drain;   // hold until every outstanding result is back
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] handle;
    logic [7:0]  seq;
    logic [31:0] source;
    logic [31:0] min_exp;
    logic        hole;
    logic        is_last;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  per_source_resequencing_buffer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the buffer state
  bit          sh_valid [NSRC];
  logic [31:0] sh_addr  [NSRC];
  bit          sh_chain [NSRC];
  logic [7:0]  sh_cseq  [NSRC];
  int          sh_cnt   [NSRC];
  logic [7:0]  sh_seq   [NSRC][NSLT];
  logic [31:0] sh_exp   [NSRC][NSLT];
  logic [15:0] sh_hdl   [NSRC][NSLT];
  int          sh_nsrc;

  req_t pending[$];
  rsp_t expected_rsp[$];
  int errors, n_sent, n_recv, cyc, idle_cyc;
  int st_seen[8];

  function automatic void clear_source(int p);
    sh_valid[p] = 0; sh_addr[p] = '0; sh_chain[p] = 0; sh_cseq[p] = '0;
    sh_cnt[p] = 0;
    for (int i = 0; i < NSLT; i++) begin
      sh_seq[p][i] = '0; sh_exp[p][i] = '0; sh_hdl[p][i] = '0;
    end
  endfunction

  function automatic void move_source(int to, int from);
    sh_valid[to] = sh_valid[from]; sh_addr[to] = sh_addr[from];
    sh_chain[to] = sh_chain[from]; sh_cseq[to] = sh_cseq[from];
    sh_cnt[to] = sh_cnt[from];
    sh_seq[to] = sh_seq[from]; sh_exp[to] = sh_exp[from]; sh_hdl[to] = sh_hdl[from];
  endfunction

  function automatic int lookup_source(logic [31:0] a);
    for (int p = 0; p < sh_nsrc; p++)
      if (sh_valid[p] && sh_addr[p] == a) return p;
    return -1;
  endfunction

  function automatic int lookup_slot(int p, logic [7:0] s);
    for (int i = 0; i < sh_cnt[p]; i++)
      if (sh_seq[p][i] == s) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int p, int i);
    int n;
    n = sh_cnt[p];
    for (int j = i; j + 1 < n; j++) begin
      sh_seq[p][j] = sh_seq[p][j+1]; sh_exp[p][j] = sh_exp[p][j+1];
      sh_hdl[p][j] = sh_hdl[p][j+1];
    end
    sh_seq[p][n-1] = '0; sh_exp[p][n-1] = '0; sh_hdl[p][n-1] = '0;
    sh_cnt[p] = n - 1;
  endfunction

  function automatic logic [31:0] source_expiry(int p);
    logic [31:0] m;
    if (sh_cnt[p] == 0) return '0;
    m = sh_exp[p][0];
    for (int i = 1; i < sh_cnt[p]; i++)
      if (sh_exp[p][i] < m) m = sh_exp[p][i];
    return m;
  endfunction

  function automatic void push_rsp(logic [2:0] st, logic [15:0] h, logic [7:0] sq,
                                   logic [31:0] src, logic [31:0] me, logic hole,
                                   logic lst);
    rsp_t r;
    r.status = st; r.handle = h; r.seq = sq; r.source = src;
    r.min_exp = me; r.hole = hole; r.is_last = lst;
    expected_rsp.push_back(r);
  endfunction

  // Advance the shadow state by one accepted request and queue its results
  function automatic void predict_results(req_t q);
    int p, si, n, i;
    logic hole;
    logic [7:0] fseq;
    logic [15:0] fh;
    logic [31:0] m, t;
    case (q.op)
      OP_ADD: begin
        p = lookup_source(q.addr);
        if (p < 0) begin
          if (sh_nsrc >= NSRC) begin
            push_rsp(ST_FULL, q.handle, q.seq, q.addr, '0, 1'b0, 1'b1);
            return;
          end
          for (int j = sh_nsrc; j > 0; j--) move_source(j, j - 1);
          clear_source(0);
          sh_valid[0] = 1; sh_addr[0] = q.addr; sh_nsrc++;
          p = 0;
        end
        n = sh_cnt[p];
        hole = (n == 0);
        if (lookup_slot(p, q.seq) >= 0) begin
          push_rsp(ST_DUP, q.handle, q.seq, q.addr, '0, hole, 1'b1);
          return;
        end
        if (n >= NSLT) begin
          push_rsp(ST_FULL, q.handle, q.seq, q.addr, '0, hole, 1'b1);
          return;
        end
        // insert ahead of the first serially later entry
        for (i = 0; i < n; i++) begin
          logic [7:0] d;
          d = sh_seq[p][i] - q.seq;
          if (d != 0 && !d[7]) break;
        end
        for (int j = n; j > i; j--) begin
          sh_seq[p][j] = sh_seq[p][j-1]; sh_exp[p][j] = sh_exp[p][j-1];
          sh_hdl[p][j] = sh_hdl[p][j-1];
        end
        sh_seq[p][i] = q.seq; sh_exp[p][i] = q.expire; sh_hdl[p][i] = q.handle;
        sh_cnt[p] = n + 1;
        push_rsp(ST_DONE, q.handle, q.seq, q.addr, '0, hole, 1'b1);
      end
      OP_TAKE: begin
        p = lookup_source(q.addr);
        si = (p >= 0) ? lookup_slot(p, q.seq) : -1;
        if (si >= 0) begin
          fh = sh_hdl[p][si];
          drop_slot(p, si);
          push_rsp(ST_DONE, fh, q.seq, q.addr, '0, 1'b0, 1'b1);
        end else begin
          push_rsp(ST_NONE, '0, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_NEXT: begin
        for (p = 0; p < sh_nsrc; p++) begin
          if (sh_cnt[p] == 0) begin
            sh_chain[p] = 0;
            continue;
          end
          fseq = sh_seq[p][0];
          fh = sh_hdl[p][0];
          if (source_expiry(p) > q.now && !sh_chain[p]) continue;
          if (sh_exp[p][0] <= q.now) begin
            sh_chain[p] = 1;
          end else if (sh_chain[p] && fseq != sh_cseq[p] + 8'd1) begin
            sh_chain[p] = 0;
            continue;
          end
          if (sh_chain[p]) sh_cseq[p] = fseq;
          drop_slot(p, 0);
          push_rsp(ST_DONE, fh, fseq, sh_addr[p], '0, 1'b0, 1'b1);
          return;
        end
        push_rsp(ST_NONE, '0, '0, '0, '0, 1'b0, 1'b1);
      end
      OP_EXPIRY: begin
        m = '0;
        for (p = 0; p < sh_nsrc; p++) begin
          t = source_expiry(p);
          if (t != 0 && (m == 0 || t < m)) m = t;
        end
        push_rsp((m != 0) ? ST_DONE : ST_NONE, '0, '0, '0, m, 1'b0, 1'b1);
      end
      OP_PURGE: begin
        p = lookup_source(q.addr);
        if (p < 0) begin
          push_rsp(ST_NONE, '0, '0, '0, '0, 1'b0, 1'b1);
          return;
        end
        n = sh_cnt[p];
        if (n == 0) push_rsp(ST_DONE, '0, '0, q.addr, '0, 1'b0, 1'b1);
        for (i = 0; i < n; i++)
          push_rsp(ST_PURGED, sh_hdl[p][i], sh_seq[p][i], q.addr, '0, 1'b0, i + 1 == n);
        for (int j = p; j + 1 < sh_nsrc; j++) move_source(j, j + 1);
        clear_source(sh_nsrc - 1);
        sh_nsrc--;
      end
      default: push_rsp(ST_NONE, '0, '0, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Sender: when the port is free, present the next queued request, with random idle gaps outside the quiet window
  always @(posedge clk) begin
    req_t q;
    bit go;
    cyc <= cyc + 1;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        q.op = s_axis_tuser; q.addr = s_axis_tdata[31:0]; q.seq = s_axis_tdata[39:32];
        q.expire = s_axis_tdata[71:40]; q.now = s_axis_tdata[103:72];
        q.handle = s_axis_tdata[119:104];
        predict_results(q);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        go = pending.size() > 0 &&
             ((cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(99, 0) >= 26);
        // drain pause: hold until the last result has come back
        if (go && pending[0].drain &&
            (expected_rsp.size() != 0 || (s_axis_tvalid && s_axis_tready)))
          go = 0;
        if (go) begin
          q = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= q.op;
          s_axis_tdata  <= {q.handle, q.now, q.expire, q.seq, q.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer against the oldest prediction
  int hold_left;
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv++;
        st_seen[m_axis_tuser[2:0]]++;
        if (n_recv == 150) hold_left = 400;   // long back-pressure stretch
        if (expected_rsp.size() == 0) begin
          $error("unexpected result transfer: status %0d", m_axis_tuser[2:0]);
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          if (m_axis_tuser[2:0] !== e.status) begin
            $error("status exp %0d got %0d", e.status, m_axis_tuser[2:0]); errors++;
          end
          if (m_axis_tdata[15:0] !== e.handle) begin
            $error("out_handle exp %h got %h", e.handle, m_axis_tdata[15:0]); errors++;
          end
          if (m_axis_tdata[23:16] !== e.seq) begin
            $error("out_seq exp %h got %h", e.seq, m_axis_tdata[23:16]); errors++;
          end
          if (m_axis_tdata[55:24] !== e.source) begin
            $error("out_source exp %h got %h", e.source, m_axis_tdata[55:24]); errors++;
          end
          if (m_axis_tdata[87:56] !== e.min_exp) begin
            $error("min_expire exp %h got %h", e.min_exp, m_axis_tdata[87:56]); errors++;
          end
          if (m_axis_tuser[3] !== e.hole) begin
            $error("hole_created exp %b got %b", e.hole, m_axis_tuser[3]); errors++;
          end
          if (m_axis_tlast !== e.is_last) begin
            $error("last exp %b got %b", e.is_last, m_axis_tlast); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(99, 0) >= 26;
      end
    end
  end

  // Watchdog: stop a run in which nothing moves
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("per_source_resequencing_buffer verification failed");
      $finish;
    end
  end

  function automatic void queue_req(logic [2:0] op, logic [31:0] a, logic [7:0] s,
                                    logic [31:0] ex, logic [31:0] nw, logic [15:0] h,
                                    bit dr = 0);
    req_t q;
    q.op = op; q.addr = a; q.seq = s; q.expire = ex; q.now = nw; q.handle = h;
    q.drain = dr;
    pending.push_back(q);
  endfunction

  logic [31:0] addr_pool[10];
  logic [7:0]  seq_base[10];
  logic [31:0] tick;

  initial begin
    int k, r;
    logic [2:0] op;
    logic [31:0] ex, nw;
    for (int p = 0; p < NSRC; p++) clear_source(p);
    sh_nsrc = 0;

    // Directed: address extremes, duplicate, absent take, empty table ops
    queue_req(OP_NEXT, '0, '0, '0, '0, '0);
    queue_req(OP_EXPIRY, '0, '0, '0, '0, '0);
    queue_req(OP_PURGE, 32'h1234, '0, '0, '0, '0);
    queue_req(OP_ADD, 32'h0, 8'hFF, 32'hFFFF_FFFF, '0, 16'hFFFF);
    queue_req(OP_ADD, 32'h0, 8'hFF, 32'h5, '0, 16'h0);
    queue_req(OP_ADD, 32'h0, 8'h00, 32'h0, '0, 16'h1);
    queue_req(OP_TAKE, 32'h0, 8'h7F, '0, '0, '0);
    queue_req(OP_TAKE, 32'h5, 8'h00, '0, '0, '0);
    queue_req(OP_EXPIRY, '0, '0, '0, '0, '0);
    queue_req(OP_TAKE, 32'h0, 8'h00, '0, '0, '0);
    queue_req(OP_RSVD_LO, 32'hFFFF_FFFF, 8'hFF, '1, '1, '1);
    queue_req(OP_RSVD_HI, '0, '0, '0, '0, '0);
    queue_req(OP_NEXT, '0, '0, '0, 32'hFFFF_FFFF, '0);
    queue_req(OP_ADD, 32'hFFFF_FFFF, 8'h10, 32'h100, '0, 16'hA5A5);
    queue_req(OP_PURGE, 32'hFFFF_FFFF, '0, '0, '0, '0);
    queue_req(OP_PURGE, 32'h0, '0, '0, '0, '0);
    // fill one source past capacity, across the sequence wrap
    for (int i = 0; i < NSLT + 1; i++)
      queue_req(OP_ADD, 32'hCAFE, 8'(8'hF8 + i), 32'(50 + i), '0, 16'(i));
    queue_req(OP_PURGE, 32'hCAFE, '0, '0, '0, '0);

    // Random: a small address pool so sources fill and the table overflows
    addr_pool[0] = '0; addr_pool[1] = '1;
    for (int i = 2; i < 10; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 10; i++) seq_base[i] = $urandom;
    tick = 32'd1000;
    for (int n = 0; n < 400; n++) begin
      k = $urandom_range(9, 0);
      r = $urandom_range(99, 0);
      tick = tick + $urandom_range(8, 0);
      op = (r < 42) ? OP_ADD : (r < 54) ? OP_TAKE : (r < 80) ? OP_NEXT :
           (r < 88) ? OP_EXPIRY : (r < 96) ? OP_PURGE : 3'($urandom_range(7, 5));
      ex = ($urandom_range(19, 0) == 0) ? $urandom :
           ($urandom_range(29, 0) == 0) ? 32'h0 : tick + $urandom_range(40, 0);
      nw = ($urandom_range(19, 0) == 0) ? $urandom : tick;
      queue_req(op, addr_pool[k], 8'(seq_base[k] + $urandom_range(18, 0)), ex, nw,
                16'($urandom), n == 250);
      if (op == OP_NEXT && $urandom_range(3, 0) == 0) seq_base[k] += 8'd3;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || s_axis_tvalid || expected_rsp.size() != 0);
    repeat (300) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d results never arrived", expected_rsp.size());
      errors++;
    end
    $display("run: %0d requests, %0d results (done %0d, none %0d, dup %0d, full %0d,",
             n_sent, n_recv, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    $display("     purged %0d) with random idling and long back-pressure", st_seen[4]);
    if (errors == 0)
      $display("per_source_resequencing_buffer verification clean");
    else
      $display("per_source_resequencing_buffer verification failed");
    $finish;
  end

endmodule
